/* src/nzid_pkg.sv */
// Shared types and constants of the near-zero integer decoder.
// Holds the query kind codes and the command and status bundles between
// the controller and the datapath. No dependencies.
package nzid_pkg;

   localparam int QUERY_INDEX_W = 5;

   typedef enum logic [2:0] {
      KIND_ZERO = 3'd0,
      KIND_SIGN = 3'd1,
      KIND_EXP  = 3'd2,
      KIND_MANT = 3'd3,
      KIND_NONE = 3'd4
   } kind_type;

   // Source of the value field in an emitted result.
   typedef enum logic [1:0] {
      VSEL_ZERO,
      VSEL_LOW,
      VSEL_FINAL
   } val_sel_type;

   typedef struct packed {
      logic        capture;
      logic        start_load;
      logic        sign_load;
      logic        pos_value;
      logic        exp_step;
      logic        mant_start;
      logic        mant_set;
      logic        scan_step;
      logic        emit;
      kind_type    kind;
      val_sel_type vsel;
   } dp_cmd_type;

   typedef struct packed {
      logic in_func;
      logic in_bit;
      logic single;
      logic both_signs;
      logic lower_zero;
      logic exp_more;
      logic pos_zero;
      logic cand_fits;
   } dp_status_type;

endpackage

/* src/near_zero_integer_decoder.sv */
// Near-zero integer decoder. An item is accepted, then decided; a decision may
// lead on to exponent checks and to a scan of mantissa positions before the
// result is registered. The controller handles one item at a time and takes
// no new item until it has registered the result of the last one; its decide,
// check and scan steps wait while a result is held unaccepted. Reset is synchronous and active high;
// it clears the controller and the result valid, and leaves the block idle.
module near_zero_integer_decoder #(
   parameter int VALUE_WIDTH = 18,
   localparam int REQ_DATA_W = ((2 * VALUE_WIDTH + 1 + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((VALUE_WIDTH + nzid_pkg::QUERY_INDEX_W + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // range_min, range_max, decoded_bit, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // value, query_index, query_sign, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // done_res, query_kind
   output logic [3:0]            rsp_tuser
);
   import nzid_pkg::*;

   localparam int W = VALUE_WIDTH;

   dp_cmd_type               cmd;
   dp_status_type            status;
   logic                     out_done;
   logic [W-1:0]             out_value;
   kind_type                 out_kind;
   logic [QUERY_INDEX_W-1:0] out_index;
   logic                     out_sign;

   nzid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nzid_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .in_func   (req_tuser),
      .in_lo     (req_tdata[W-1:0]),
      .in_hi     (req_tdata[2*W-1:W]),
      .in_bit    (req_tdata[2*W]),
      .status    (status),
      .out_done  (out_done),
      .out_value (out_value),
      .out_kind  (out_kind),
      .out_index (out_index),
      .out_sign  (out_sign)
   );

   always_comb begin
      rsp_tdata                         = '0;
      rsp_tdata[W-1:0]                  = out_value;
      rsp_tdata[W+QUERY_INDEX_W-1:W]    = out_index;
      rsp_tdata[W+QUERY_INDEX_W]        = out_sign;
      rsp_tuser                         = {out_kind, out_done};
   end

endmodule

/* src/nzid_dp.sv */
// Datapath of the near-zero integer decoder: captured item, shifted bounds,
// exponent and mantissa registers, and the result register.
// Depends on nzid_pkg; driven by nzid_ctrl through dp_cmd_type.
module nzid_dp #(
   parameter int VALUE_WIDTH = 18
) (
   input  logic                                  clock,
   input  nzid_pkg::dp_cmd_type                  cmd,
   input  logic                                  in_func,
   input  logic signed [VALUE_WIDTH-1:0]         in_lo,
   input  logic signed [VALUE_WIDTH-1:0]         in_hi,
   input  logic                                  in_bit,
   output nzid_pkg::dp_status_type               status,
   output logic                                  out_done,
   output logic        [VALUE_WIDTH-1:0]         out_value,
   output nzid_pkg::kind_type                    out_kind,
   output logic        [nzid_pkg::QUERY_INDEX_W-1:0] out_index,
   output logic                                  out_sign
);
   import nzid_pkg::*;

   localparam int W = VALUE_WIDTH;

   logic                    in_func_ff;
   logic                    in_bit_ff;
   logic signed [W-1:0]     lo_ff;
   logic signed [W-1:0]     hi_ff;
   logic        [W-1:0]     offset_ff;
   logic        [W-1:0]     upper_ff;
   logic        [W-1:0]     lower_ff;
   logic        [W-1:0]     limit_ff;
   logic                    positive_ff;
   logic        [W-1:0]     pow_ff;
   logic [QUERY_INDEX_W-1:0] exponent_ff;
   logic        [W-1:0]     so_far_ff;
   logic        [W-1:0]     mbit_ff;
   logic [QUERY_INDEX_W-1:0] bitpos_ff;

   logic                    done_ff;
   logic        [W-1:0]     value_ff;
   kind_type                kind_ff;
   logic [QUERY_INDEX_W-1:0] index_ff;
   logic                    sign_ff;

   logic                    lo_pos;
   logic                    hi_neg;
   logic        [W:0]       diff_w;
   logic        [W:0]       neglo_w;
   logic        [W-1:0]     offset_in;
   logic        [W-1:0]     upper_in;
   logic        [W-1:0]     lower_in;
   logic        [W:0]       mag_w;
   logic        [W:0]       smag_w;
   logic        [W:0]       sum_w;
   logic        [W-1:0]     value_in;
   logic [QUERY_INDEX_W-1:0] index_in;
   logic                    sign_in;

   // A range wholly above or below zero is shifted so that it holds zero.
   always_comb begin
      lo_pos  = !lo_ff[W-1] && (lo_ff != '0);
      hi_neg  = hi_ff[W-1];
      diff_w  = {hi_ff[W-1], hi_ff} - {lo_ff[W-1], lo_ff};
      neglo_w = '0 - {lo_ff[W-1], lo_ff};
      if (lo_pos) begin
         offset_in = lo_ff;
         upper_in  = diff_w[W-1:0];
         lower_in  = '0;
      end else if (hi_neg) begin
         offset_in = hi_ff;
         upper_in  = '0;
         lower_in  = diff_w[W-1:0];
      end else begin
         offset_in = '0;
         upper_in  = hi_ff;
         lower_in  = neglo_w[W-1:0];
      end
   end

   always_comb begin
      mag_w  = {1'b0, so_far_ff};
      smag_w = positive_ff ? mag_w : ('0 - mag_w);
      sum_w  = smag_w + {offset_ff[W-1], offset_ff};
      unique case (cmd.vsel)
         VSEL_LOW:   value_in = lo_ff;
         VSEL_FINAL: value_in = sum_w[W-1:0];
         default:    value_in = '0;
      endcase
      unique case (cmd.kind)
         KIND_EXP:  index_in = exponent_ff;
         KIND_MANT: index_in = bitpos_ff - QUERY_INDEX_W'(1);
         default:   index_in = '0;
      endcase
      sign_in = (cmd.kind == KIND_EXP) ? positive_ff : 1'b0;
   end

   always_comb begin
      status.in_func    = in_func_ff;
      status.in_bit     = in_bit_ff;
      status.single     = (hi_ff <= lo_ff);
      status.both_signs = (lower_ff != '0) && (upper_ff != '0);
      status.lower_zero = (lower_ff == '0);
      // exponent < floor(log2(limit)) holds exactly when 2^exponent <= limit / 2.
      status.exp_more   = ((limit_ff >> 1) >= pow_ff);
      status.pos_zero   = (bitpos_ff == '0);
      status.cand_fits  = ((so_far_ff | (mbit_ff >> 1)) <= limit_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_func_ff <= in_func;
         in_bit_ff  <= in_bit;
         if (!in_func) begin
            lo_ff <= in_lo;
            hi_ff <= in_hi;
         end
      end
      if (cmd.start_load) begin
         offset_ff   <= offset_in;
         upper_ff    <= upper_in;
         lower_ff    <= lower_in;
         positive_ff <= 1'b0;
         so_far_ff   <= '0;
         exponent_ff <= '0;
         bitpos_ff   <= '0;
      end
      if (cmd.sign_load) begin
         positive_ff <= cmd.pos_value;
         limit_ff    <= cmd.pos_value ? upper_ff : lower_ff;
         pow_ff      <= W'(1);
         exponent_ff <= '0;
      end
      if (cmd.exp_step) begin
         pow_ff      <= pow_ff << 1;
         exponent_ff <= exponent_ff + QUERY_INDEX_W'(1);
      end
      if (cmd.mant_start) begin
         so_far_ff <= pow_ff;
         mbit_ff   <= pow_ff;
         bitpos_ff <= exponent_ff;
      end
      if (cmd.mant_set) begin
         so_far_ff <= so_far_ff | mbit_ff;
      end
      if (cmd.scan_step) begin
         mbit_ff   <= mbit_ff >> 1;
         bitpos_ff <= bitpos_ff - QUERY_INDEX_W'(1);
      end
      if (cmd.emit) begin
         done_ff  <= (cmd.vsel != VSEL_ZERO);
         value_ff <= value_in;
         kind_ff  <= cmd.kind;
         index_ff <= index_in;
         sign_ff  <= sign_in;
      end
   end

   assign out_done  = done_ff;
   assign out_value = value_ff;
   assign out_kind  = kind_ff;
   assign out_index = index_ff;
   assign out_sign  = sign_ff;

endmodule

/* src/nzid_ctrl.sv */
// Controller of the near-zero integer decoder: decode phase, sequencing of
// exponent checks and mantissa scans, and the result handshake.
// Depends on nzid_pkg; commands nzid_dp.
module nzid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  nzid_pkg::dp_status_type status,
   output nzid_pkg::dp_cmd_type    cmd
);
   import nzid_pkg::*;

   typedef enum logic [1:0] {
      S_RECV,
      S_DECIDE,
      S_EXPCHK,
      S_SCAN
   } state_type;

   typedef enum logic [1:0] {
      PH_ZERO,
      PH_SIGN,
      PH_EXP,
      PH_MANT
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      state_in   = state_ff;
      phase_in   = phase_ff;
      busy_in    = busy_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.kind   = KIND_NONE;
      cmd.vsel   = VSEL_ZERO;

      unique case (state_ff)
         S_RECV: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               state_in = S_RECV;
               if (!status.in_func) begin
                  phase_in = PH_ZERO;
                  cmd.emit = 1'b1;
                  if (status.single) begin
                     busy_in  = 1'b0;
                     cmd.vsel = VSEL_LOW;
                  end else begin
                     busy_in        = 1'b1;
                     cmd.start_load = 1'b1;
                     cmd.kind       = KIND_ZERO;
                  end
               end else if (!busy_ff) begin
                  cmd.emit = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_ZERO: begin
                        if (status.in_bit) begin
                           // The magnitude is still zero, so the result is the offset.
                           cmd.emit = 1'b1;
                           cmd.vsel = VSEL_FINAL;
                           busy_in  = 1'b0;
                        end else if (status.both_signs) begin
                           cmd.emit = 1'b1;
                           cmd.kind = KIND_SIGN;
                           phase_in = PH_SIGN;
                        end else begin
                           cmd.sign_load = 1'b1;
                           cmd.pos_value = status.lower_zero;
                           state_in      = S_EXPCHK;
                        end
                     end
                     PH_SIGN: begin
                        cmd.sign_load = 1'b1;
                        cmd.pos_value = status.in_bit;
                        state_in      = S_EXPCHK;
                     end
                     PH_EXP: begin
                        if (status.in_bit) begin
                           cmd.mant_start = 1'b1;
                           state_in       = S_SCAN;
                        end else begin
                           cmd.exp_step = 1'b1;
                           state_in     = S_EXPCHK;
                        end
                     end
                     PH_MANT: begin
                        cmd.mant_set = status.in_bit;
                        state_in     = S_SCAN;
                     end
                     default: state_in = S_RECV;
                  endcase
               end
            end
         end
         S_EXPCHK: begin
            if (out_free) begin
               if (status.exp_more) begin
                  cmd.emit = 1'b1;
                  cmd.kind = KIND_EXP;
                  phase_in = PH_EXP;
                  state_in = S_RECV;
               end else begin
                  cmd.mant_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // One mantissa position per cycle while no result is held unaccepted; positions
            // that would exceed the magnitude limit are passed over without a query.
            if (out_free) begin
               if (status.pos_zero) begin
                  cmd.emit = 1'b1;
                  cmd.vsel = VSEL_FINAL;
                  busy_in  = 1'b0;
                  phase_in = PH_ZERO;
                  state_in = S_RECV;
               end else begin
                  cmd.scan_step = 1'b1;
                  if (status.cand_fits) begin
                     cmd.emit = 1'b1;
                     cmd.kind = KIND_MANT;
                     phase_in = PH_MANT;
                     state_in = S_RECV;
                  end
               end
            end
         end
         default: state_in = S_RECV;
      endcase

      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RECV;
         phase_ff     <= PH_ZERO;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* src/nzid_checker.sv */
// Port-level checks for the near-zero integer decoder, bound to the top level.
// Depends on nzid_pkg and near_zero_integer_decoder.
module nzid_props #(
   parameter int VALUE_WIDTH = 18,
   localparam int RSP_DATA_W = ((VALUE_WIDTH + nzid_pkg::QUERY_INDEX_W + 1 + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [3:0]            rsp_tuser
);
   import nzid_pkg::*;

   // A finished integer never carries a pending decision.
   a_done_no_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tuser[3:1] == KIND_NONE))
      else $error("finished result carries a query kind");

   // Each accepted item is worked on before the next one is taken.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken in the cycle after an accept");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

endmodule

bind near_zero_integer_decoder nzid_props #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_nzid_props (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
